@@ design/pldf_pkg.sv @@
// ----------------------------------------------------------------------------
// pldf_pkg
// Shared widths, register codes and beat types for the point to line
// distance filter.
// ----------------------------------------------------------------------------
package pldf_pkg;

	// Coordinate and direction formats
	localparam int COORD_W       = 16;
	localparam int DIR_FRAC_BITS = 14;
	localparam int DIR_W         = DIR_FRAC_BITS + 2;

	// Limb size used to split wide products
	localparam int LIMB_W = 16;

	// Datapath widths, all exact
	localparam int D_W   = COORD_W + 1;                 // point minus anchor
	localparam int DP_W  = D_W + DIR_W;                 // one term of the dot product
	localparam int T_W   = DP_W + 2;                    // dot product, scale 2^F
	localparam int TP_W  = T_W + DIR_W;                 // t times direction
	localparam int DS_W  = D_W + 2 * DIR_FRAC_BITS;     // d scaled by 2^(2F)
	localparam int R_W   = ((TP_W > DS_W) ? TP_W : DS_W) + 1;
	localparam int SQ_W  = 2 * R_W;                     // squared residual component
	localparam int R2_W  = SQ_W + 2;                    // squared residual length
	localparam int MSQ_W = 2 * COORD_W;                 // squared max distance

	// Pipeline stages ahead of the output register
	localparam int NSTAGE = 13;

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = (COORD_W > DIR_W) ? COORD_W : DIR_W;

	localparam logic [CFG_ADDR_W-1:0] REG_ANCHOR_X     = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ANCHOR_Y     = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_ANCHOR_Z     = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_DIR_X        = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_DIR_Y        = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_DIR_Z        = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_DISTANCE = 3'd6;

	// Unit length in Q1.F
	localparam logic [DIR_W-1:0] DIR_ONE = DIR_W'(1) << DIR_FRAC_BITS;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] kept_x;
		logic signed [COORD_W-1:0] kept_y;
		logic signed [COORD_W-1:0] kept_z;
	} out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] anchor_x;
		logic signed [COORD_W-1:0] anchor_y;
		logic signed [COORD_W-1:0] anchor_z;
		logic signed [DIR_W-1:0]   dir_x;
		logic signed [DIR_W-1:0]   dir_y;
		logic signed [DIR_W-1:0]   dir_z;
		logic [MSQ_W-1:0]          max_dist_sq;
	} cfg_t;

endpackage

@@ design/pldf_cfg.sv @@
// ----------------------------------------------------------------------------
// pldf_cfg
// Configuration registers of the filter: line anchor, line direction and
// distance limit, plus the registered square of the limit.
// ----------------------------------------------------------------------------
module pldf_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [pldf_pkg::CFG_ADDR_W-1:0]     addr,
	input  logic [pldf_pkg::CFG_DATA_W-1:0]     wdata,
	output pldf_pkg::cfg_t                      cfg
);

	logic signed [pldf_pkg::COORD_W-1:0] anchor_x_q;
	logic signed [pldf_pkg::COORD_W-1:0] anchor_y_q;
	logic signed [pldf_pkg::COORD_W-1:0] anchor_z_q;
	logic signed [pldf_pkg::DIR_W-1:0]   dir_x_q;
	logic signed [pldf_pkg::DIR_W-1:0]   dir_y_q;
	logic signed [pldf_pkg::DIR_W-1:0]   dir_z_q;
	logic [pldf_pkg::COORD_W-1:0]        max_distance_q;
	logic [pldf_pkg::MSQ_W-1:0]          max_dist_sq_q;

	// Decode writes; keep only the low bits of the write data for each register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_x_q     <= '0;
			anchor_y_q     <= '0;
			anchor_z_q     <= '0;
			dir_x_q        <= pldf_pkg::DIR_ONE;
			dir_y_q        <= '0;
			dir_z_q        <= '0;
			max_distance_q <= '0;
		end else if (wr_en) begin
			unique case (addr)
				pldf_pkg::REG_ANCHOR_X:     anchor_x_q     <= wdata[pldf_pkg::COORD_W-1:0];
				pldf_pkg::REG_ANCHOR_Y:     anchor_y_q     <= wdata[pldf_pkg::COORD_W-1:0];
				pldf_pkg::REG_ANCHOR_Z:     anchor_z_q     <= wdata[pldf_pkg::COORD_W-1:0];
				pldf_pkg::REG_DIR_X:        dir_x_q        <= wdata[pldf_pkg::DIR_W-1:0];
				pldf_pkg::REG_DIR_Y:        dir_y_q        <= wdata[pldf_pkg::DIR_W-1:0];
				pldf_pkg::REG_DIR_Z:        dir_z_q        <= wdata[pldf_pkg::DIR_W-1:0];
				pldf_pkg::REG_MAX_DISTANCE: max_distance_q <= wdata[pldf_pkg::COORD_W-1:0];
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	// Square the limit in its own register, off the item path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_sq_q <= '0;
		end else begin
			max_dist_sq_q <= pldf_pkg::MSQ_W'(max_distance_q)
				* pldf_pkg::MSQ_W'(max_distance_q);
		end
	end

	assign cfg.anchor_x    = anchor_x_q;
	assign cfg.anchor_y    = anchor_y_q;
	assign cfg.anchor_z    = anchor_z_q;
	assign cfg.dir_x       = dir_x_q;
	assign cfg.dir_y       = dir_y_q;
	assign cfg.dir_z       = dir_z_q;
	assign cfg.max_dist_sq = max_dist_sq_q;

endmodule

@@ design/pldf_mul.sv @@
// ----------------------------------------------------------------------------
// pldf_mul
// Three-stage signed multiplier. Operands are split into limbs, limb
// products are registered, then summed per row, then summed across rows.
// ----------------------------------------------------------------------------
module pldf_mul #(
	parameter int A_W = pldf_pkg::D_W,
	parameter int B_W = pldf_pkg::DIR_W
) (
	input  logic                      clk,
	input  logic [2:0]                en,
	input  logic signed [A_W-1:0]     a,
	input  logic signed [B_W-1:0]     b,
	output logic signed [A_W+B_W-1:0] p
);

	localparam int L   = pldf_pkg::LIMB_W;
	localparam int NA  = (A_W + L - 1) / L;
	localparam int NB  = (B_W + L - 1) / L;
	localparam int XA  = NA * L;
	localparam int XB  = NB * L;
	localparam int P_W = A_W + B_W;

	logic signed [XA-1:0]    ax;
	logic signed [XB-1:0]    bx;
	logic signed [L:0]       la [NA];
	logic signed [L:0]       lb [NB];
	logic signed [2*L+1:0]   pp_s1 [NA][NB];
	logic signed [P_W-1:0]   row [NA];
	logic signed [P_W-1:0]   row_s2 [NA];
	logic signed [P_W-1:0]   total;
	logic signed [P_W-1:0]   p_s3;

	assign ax = XA'(a);
	assign bx = XB'(b);

	// Cut operands into limbs; only the top limb carries the sign
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			if (i == NA - 1) begin
				la[i] = {ax[XA-1], ax[i*L +: L]};
			end else begin
				la[i] = {1'b0, ax[i*L +: L]};
			end
		end
		for (int j = 0; j < NB; j++) begin
			if (j == NB - 1) begin
				lb[j] = {bx[XB-1], bx[j*L +: L]};
			end else begin
				lb[j] = {1'b0, bx[j*L +: L]};
			end
		end
	end

	// Stage 1: limb products
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= la[i] * lb[j];
				end
			end
		end
	end

	// Stage 2: weight and sum each row
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row[i] = row[i] + (P_W'(pp_s1[i][j]) <<< (j * L));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			row_s2 <= row;
		end
	end

	// Stage 3: weight and sum the rows
	always_comb begin
		total = '0;
		for (int i = 0; i < NA; i++) begin
			total = total + (row_s2[i] <<< (i * L));
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			p_s3 <= total;
		end
	end

	assign p = p_s3;

endmodule

@@ design/point_line_distance_filter_top.sv @@
// ----------------------------------------------------------------------------
// point_line_distance_filter_top: an accepted point goes through the 13-stage
// compute pipeline and output register to its kept beat on the output;
// throughput one point per cycle while out_stall does not hold the pipeline.
// Reset clears all valid flags; loads anchor 0, direction +x, distance limit 0.
// ----------------------------------------------------------------------------
module point_line_distance_filter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [pldf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [pldf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  pldf_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output pldf_pkg::out_t                      out_data
);

	localparam int NS = pldf_pkg::NSTAGE;
	localparam int F  = pldf_pkg::DIR_FRAC_BITS;

	pldf_pkg::cfg_t cfg;

	logic [NS+1:1]                        adv;
	logic [NS:1]                          vld_s;
	logic [NS:1]                          vld_nxt;
	pldf_pkg::in_t                        pt_s [1:NS];

	logic signed [pldf_pkg::COORD_W-1:0]  pin   [3];
	logic signed [pldf_pkg::COORD_W-1:0]  pt8   [3];
	logic signed [pldf_pkg::COORD_W-1:0]  ank   [3];
	logic signed [pldf_pkg::DIR_W-1:0]    dir   [3];
	logic signed [pldf_pkg::D_W-1:0]      d8    [3];

	logic signed [pldf_pkg::D_W-1:0]      d_s1  [3];
	logic signed [pldf_pkg::DP_W-1:0]     dp    [3];
	logic signed [pldf_pkg::T_W-1:0]      t_s5;
	logic signed [pldf_pkg::TP_W-1:0]     tp    [3];
	logic signed [pldf_pkg::R_W-1:0]      r_s9  [3];
	logic signed [pldf_pkg::SQ_W-1:0]     sq    [3];
	logic signed [pldf_pkg::R2_W-1:0]     r2_s13;
	logic [pldf_pkg::R2_W-1:0]            lim;
	logic                                 keep;

	logic                                 out_valid_q;
	pldf_pkg::out_t                       out_data_q;

	pldf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.addr   (cfg_addr),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// Per-axis views of point and line
	assign pin[0] = in_data.point_x;
	assign pin[1] = in_data.point_y;
	assign pin[2] = in_data.point_z;
	assign pt8[0] = pt_s[8].point_x;
	assign pt8[1] = pt_s[8].point_y;
	assign pt8[2] = pt_s[8].point_z;
	assign ank[0] = cfg.anchor_x;
	assign ank[1] = cfg.anchor_y;
	assign ank[2] = cfg.anchor_z;
	assign dir[0] = cfg.dir_x;
	assign dir[1] = cfg.dir_y;
	assign dir[2] = cfg.dir_z;

	// A stage advances when it is empty or the stage after it advances
	always_comb begin
		adv[NS+1] = !out_valid_q || !out_stall;
		for (int k = NS; k >= 1; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign in_stall = !adv[1];
	assign vld_nxt  = {vld_s[NS-1:1], in_valid};

	// Valid flags travel with the beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_nxt[k];
				end
			end
		end
	end

	// Carry the point along for the output beat
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			pt_s[1] <= in_data;
		end
		for (int k = 2; k <= NS; k++) begin
			if (adv[k]) begin
				pt_s[k] <= pt_s[k-1];
			end
		end
	end

	// Stage 1: offset from the anchor
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= pldf_pkg::D_W'(pin[i]) - pldf_pkg::D_W'(ank[i]);
			end
		end
	end

	// Stages 2 to 4: offset times direction, per axis
	for (genvar g = 0; g < 3; g++) begin : g_dot
		pldf_mul #(
			.A_W (pldf_pkg::D_W),
			.B_W (pldf_pkg::DIR_W)
		) u_mul_dot (
			.clk (clk),
			.en  (adv[4:2]),
			.a   (d_s1[g]),
			.b   (dir[g]),
			.p   (dp[g])
		);
	end

	// Stage 5: projection length t
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			t_s5 <= pldf_pkg::T_W'(dp[0]) + pldf_pkg::T_W'(dp[1])
				+ pldf_pkg::T_W'(dp[2]);
		end
	end

	// Stages 6 to 8: t times direction, per axis
	for (genvar g = 0; g < 3; g++) begin : g_proj
		pldf_mul #(
			.A_W (pldf_pkg::T_W),
			.B_W (pldf_pkg::DIR_W)
		) u_mul_proj (
			.clk (clk),
			.en  (adv[8:6]),
			.a   (t_s5),
			.b   (dir[g]),
			.p   (tp[g])
		);
	end

	// Stage 9: residual, offset rebuilt from the carried point
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d8[i] = pldf_pkg::D_W'(pt8[i]) - pldf_pkg::D_W'(ank[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			for (int i = 0; i < 3; i++) begin
				r_s9[i] <= (pldf_pkg::R_W'(d8[i]) <<< (2 * F)) - pldf_pkg::R_W'(tp[i]);
			end
		end
	end

	// Stages 10 to 12: square each residual component
	for (genvar g = 0; g < 3; g++) begin : g_sq
		pldf_mul #(
			.A_W (pldf_pkg::R_W),
			.B_W (pldf_pkg::R_W)
		) u_mul_sq (
			.clk (clk),
			.en  (adv[12:10]),
			.a   (r_s9[g]),
			.b   (r_s9[g]),
			.p   (sq[g])
		);
	end

	// Stage 13: squared residual length
	always_ff @(posedge clk) begin
		if (adv[13]) begin
			r2_s13 <= pldf_pkg::R2_W'(sq[0]) + pldf_pkg::R2_W'(sq[1])
				+ pldf_pkg::R2_W'(sq[2]);
		end
	end

	// Compare with the scaled squared limit; equal counts as kept
	assign lim  = pldf_pkg::R2_W'(cfg.max_dist_sq) << (4 * F);
	assign keep = $unsigned(r2_s13) <= lim;

	// Output register: drop far points, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv[NS+1]) begin
			out_valid_q <= vld_s[NS] && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NS+1]) begin
			out_data_q.kept_x <= pt_s[NS].point_x;
			out_data_q.kept_y <= pt_s[NS].point_y;
			out_data_q.kept_z <= pt_s[NS].point_z;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
